### hw/rtl/lclp_pkg.sv
// Shared types, constants and gain curve generation for the LED luminance pattern block.
package lclp_pkg;

	localparam int MAX_CHANNELS  = 64;
	localparam int CURVE_ENTRIES = 1024;
	localparam int CURVE_AW      = $clog2(CURVE_ENTRIES);
	localparam int TIME_W        = 32;
	localparam int IVL_W         = 16;
	localparam int CNT_W         = $clog2(MAX_CHANNELS + 1);
	localparam int D_W           = $clog2(MAX_CHANNELS) + IVL_W;
	localparam int RATIO_W       = 17;
	localparam int MOD_STAGES    = TIME_W;
	localparam int DIV_STAGES    = RATIO_W;

	localparam logic [RATIO_W-1:0] RATIO_ONE  = RATIO_W'(65536);
	localparam logic [RATIO_W-1:0] RATIO_HALF = RATIO_W'(32768);
	localparam logic [63:0] Q30_ONE = 64'd1 << 30;
	localparam logic [63:0] CURVE_NN = 64'(CURVE_ENTRIES) * 64'(CURVE_ENTRIES);

	typedef enum logic [2:0] {
		MODE_FLASH    = 3'd0,
		MODE_ON       = 3'd1,
		MODE_WHITE    = 3'd2,
		MODE_STOP     = 3'd3,
		MODE_FLOW     = 3'd4,
		MODE_STROBE_W = 3'd5,
		MODE_STROBE_C = 3'd6,
		MODE_GAIN     = 3'd7
	} mode_t;

	typedef enum logic [2:0] {
		REG_CHANNEL_COUNT   = 3'd0,
		REG_FLOW_INTERVAL   = 3'd1,
		REG_FLOW_LENGTH     = 3'd2,
		REG_STROBE_INTERVAL = 3'd3,
		REG_STROBE_LENGTH   = 3'd4,
		REG_COLOR_LOW       = 3'd5,
		REG_COLOR_HIGH      = 3'd6,
		REG_MODE_FLAGS      = 3'd7
	} cfg_reg_t;

	typedef enum logic [2:0] {
		SRC_DIV,
		SRC_ZERO,
		SRC_GAIN,
		SRC_ONE,
		SRC_HALF
	} src_t;

	typedef enum logic [1:0] {
		PAL_COLOR,
		PAL_STROBE_W,
		PAL_FULL_W
	} pal_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [31:0] time_now;
		logic [5:0]  channel_index;
		logic [9:0]  gain_amplitude;
		logic        beat_lock;
		logic [15:0] beat_period;
		logic [31:0] last_beat_time;
	} item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] white;
	} result_t;

	typedef struct packed {
		mode_t              mode;
		logic [CURVE_AW-1:0] gidx;
		logic               lock_en;
		logic               flash_ok;
		logic [IVL_W-1:0]   fl_num;
		logic [IVL_W-1:0]   period;
		logic [D_W-1:0]     d;
		logic [D_W-1:0]     chiv;
	} mod_side_t;

	typedef struct packed {
		src_t                src;
		pal_t                pal;
		logic [CURVE_AW-1:0] gidx;
	} div_side_t;

	typedef logic [63:0] root_tab_t [31];
	typedef logic [RATIO_W-1:0] curve_tab_t [CURVE_ENTRIES];

	function automatic logic [63:0] isqrt64(logic [63:0] v);
		logic [63:0] res;
		logic [63:0] b;
		logic [63:0] vv;
		res = '0;
		vv = v;
		b = 64'd1 << 62;
		while (b > vv) b = b >> 2;
		while (b != 0) begin
			if (vv >= res + b) begin
				vv = vv - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic root_tab_t build_roots();
		root_tab_t rt;
		rt[0] = Q30_ONE;
		rt[1] = isqrt64(64'd1 << 59);
		for (int j = 1; j < 30; j++) rt[j+1] = isqrt64(rt[j] << 30);
		return rt;
	endfunction

	// y^(3/20) or y^(3/10) in Q16 from y in Q32, through log2 and a product of roots
	function automatic logic [RATIO_W-1:0] curve_pow(logic [63:0] y32, bit fest,
			root_tab_t rt);
		int          p;
		logic [63:0] m;
		logic [63:0] f_log;
		logic [63:0] lg;
		logic [63:0] e;
		logic [63:0] n;
		logic [63:0] fr;
		logic [63:0] r;
		p = 0;
		f_log = '0;
		r = Q30_ONE;
		if (y32 == 0) return '0;
		while ((y32 >> (p + 1)) != 0) p++;
		m = (p <= 30) ? (y32 << (30 - p)) : (y32 >> (p - 30));
		for (int k = 0; k < 30; k++) begin
			m = (m * m) >> 30;
			f_log = f_log << 1;
			if (m >= (64'd2 << 30)) begin
				m = m >> 1;
				f_log = f_log | 64'd1;
			end
		end
		lg = (64'(32 - p) << 30) - f_log;
		e = fest ? (lg * 64'd3) / 64'd10 : (lg * 64'd3) / 64'd20;
		n = e >> 30;
		fr = e & (Q30_ONE - 64'd1);
		for (int j = 1; j <= 30; j++)
			if (fr[30-j]) r = (r * rt[j]) >> 30;
		r = (n >= 40) ? 64'd0 : (r >> n);
		return RATIO_W'((r + 64'd8192) >> 14);
	endfunction

	function automatic curve_tab_t build_curve(bit fest);
		curve_tab_t  tab;
		root_tab_t   rt;
		logic [63:0] q;
		logic [63:0] y;
		rt = build_roots();
		for (int i = 0; i < CURVE_ENTRIES; i++) begin
			q = 64'd4 * 64'(i) * 64'(CURVE_ENTRIES - i);
			y = (q << 32) / CURVE_NN;
			tab[i] = curve_pow(y, fest, rt);
		end
		return tab;
	endfunction

endpackage

### hw/rtl/led_channel_luminance_pattern.sv
// Top level of the LED channel luminance pattern block.
// Use: each transfer on the item channel (item_valid, item_stall, item) asks for
// the RGBW bytes of one channel at one time in one pattern mode; exactly one
// transfer on the result channel (result_valid, result_stall, result) answers it,
// in order. Registers are written through cfg_we, cfg_index and cfg_data; the user
// must do so only while no item is in flight, which the block does not enforce.
// Between item transfer and result valid lie the 32-stage time remainder pipeline,
// the 17-stage ratio divider and five stages of operand setup, ratio selection,
// curve ROM read and colour blend.
// Throughput: one item per cycle unless a result stalls; every stage has its own register.
// Reset clears all valid bits and loads the register reset values; the curve
// tables are constant and need no fill.
// When the receiver stalls a valid result, the whole pipeline holds and
// item_stall rises in the same cycle; nothing is dropped or repeated.
module led_channel_luminance_pattern
	import lclp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  item_t       item,
	output logic        result_valid,
	input  logic        result_stall,
	output result_t     result,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic [6:0]       channel_count_q;
	logic [IVL_W-1:0] flow_interval_q;
	logic [IVL_W-1:0] flow_length_q;
	logic [IVL_W-1:0] strobe_interval_q;
	logic [IVL_W-1:0] strobe_length_q;
	logic [31:0]      color_low_q;
	logic [31:0]      color_high_q;
	logic [1:0]       mode_flags_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_count_q   <= 7'd1;
			flow_interval_q   <= IVL_W'(100);
			flow_length_q     <= IVL_W'(100);
			strobe_interval_q <= IVL_W'(100);
			strobe_length_q   <= IVL_W'(100);
			color_low_q       <= '0;
			color_high_q      <= '0;
			mode_flags_q      <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_CHANNEL_COUNT:   channel_count_q   <= cfg_data[6:0];
				REG_FLOW_INTERVAL:   flow_interval_q   <= cfg_data[IVL_W-1:0];
				REG_FLOW_LENGTH:     flow_length_q     <= cfg_data[IVL_W-1:0];
				REG_STROBE_INTERVAL: strobe_interval_q <= cfg_data[IVL_W-1:0];
				REG_STROBE_LENGTH:   strobe_length_q   <= cfg_data[IVL_W-1:0];
				REG_COLOR_LOW:       color_low_q       <= cfg_data;
				REG_COLOR_HIGH:      color_high_q      <= cfg_data;
				REG_MODE_FLAGS:      mode_flags_q      <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	logic adv;
	logic vld_s5;
	assign adv        = !(vld_s5 && result_stall);
	assign item_stall = !adv;

	// stage 1: chase period, channel offset and beat-lock operands
	mode_t            in_mode;
	logic [CNT_W-1:0] cnt_eff;
	logic [IVL_W-1:0] iv_sel;
	logic [IVL_W-1:0] iv_eff;
	logic [32:0]      dt;
	logic [CURVE_AW+9:0] gprod;
	logic [CURVE_AW-1:0] gidx;
	mod_side_t        side_c;

	assign in_mode = mode_t'(item.mode);
	assign cnt_eff = (channel_count_q == 7'd0) ? CNT_W'(1) :
		(int'(channel_count_q) > MAX_CHANNELS) ? CNT_W'(MAX_CHANNELS) : CNT_W'(channel_count_q);
	assign iv_sel  = (in_mode == MODE_FLOW) ? flow_interval_q : strobe_interval_q;
	assign iv_eff  = (iv_sel == '0) ? IVL_W'(1) : iv_sel;
	assign dt      = {1'b0, item.time_now} - {1'b0, item.last_beat_time};
	assign gprod   = (CURVE_AW+10)'(item.gain_amplitude) * (CURVE_AW+10)'(CURVE_ENTRIES);
	assign gidx    = ((gprod >> 10) >= (CURVE_AW+10)'(CURVE_ENTRIES)) ?
		CURVE_AW'(CURVE_ENTRIES - 1) : CURVE_AW'(gprod >> 10);

	always_comb begin
		side_c.mode     = in_mode;
		side_c.gidx     = gidx;
		side_c.lock_en  = item.beat_lock && (item.beat_period != '0);
		side_c.flash_ok = !dt[32] && (dt[31:0] <= {16'b0, item.beat_period});
		side_c.fl_num   = item.beat_period - dt[IVL_W-1:0];
		side_c.period   = item.beat_period;
		side_c.d        = D_W'(cnt_eff) * D_W'(iv_eff);
		side_c.chiv     = D_W'(item.channel_index) * D_W'(iv_eff);
	end

	logic              vld_s1;
	logic [TIME_W-1:0] now_s1;
	mod_side_t         side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			now_s1  <= item.time_now;
			side_s1 <= side_c;
		end
	end

	logic           mod_vld;
	logic [D_W-1:0] mod_rem;
	mod_side_t      mod_side;

	lclp_mod_pipe u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (vld_s1),
		.in_num    (now_s1),
		.in_side   (side_s1),
		.out_valid (mod_vld),
		.out_rem   (mod_rem),
		.out_side  (mod_side)
	);

	// stage 2: pick the ramp offset and the divider operands
	logic [D_W+1:0]   a0;
	logic [D_W+1:0]   a1;
	logic [IVL_W-1:0] len_sel;
	logic [IVL_W-1:0] len_eff;
	logic             a0_ok;
	logic             a1_ok;
	logic [IVL_W-1:0] num_c;
	logic [IVL_W-1:0] den_c;
	div_side_t        dside_c;

	assign a0      = {2'b0, mod_rem} - {2'b0, mod_side.chiv};
	assign a1      = a0 + {2'b0, mod_side.d};
	assign len_sel = (mod_side.mode == MODE_FLOW) ? flow_length_q : strobe_length_q;
	assign len_eff = (len_sel == '0) ? IVL_W'(1) : len_sel;
	assign a0_ok   = !a0[D_W+1] && (a0 <= (D_W+2)'(len_eff));
	assign a1_ok   = !a1[D_W+1] && (a1 <= (D_W+2)'(len_eff));

	always_comb begin
		num_c        = '0;
		den_c        = IVL_W'(1);
		dside_c.src  = SRC_ZERO;
		dside_c.pal  = PAL_COLOR;
		dside_c.gidx = mod_side.gidx;
		case (mod_side.mode)
			MODE_FLASH: begin
				if (mod_side.lock_en) begin
					dside_c.src = mod_side.flash_ok ? SRC_DIV : SRC_ZERO;
					num_c       = mod_side.fl_num;
					den_c       = mod_side.period;
				end else begin
					dside_c.src = SRC_GAIN;
				end
			end
			MODE_ON:    dside_c.src = SRC_ONE;
			MODE_WHITE: dside_c.pal = PAL_FULL_W;
			MODE_STOP:  dside_c.src = SRC_HALF;
			MODE_FLOW, MODE_STROBE_W, MODE_STROBE_C: begin
				// strobes stay on the low colour unless a flag enables them
				if (mod_side.mode == MODE_FLOW || mode_flags_q != 2'b00) begin
					if (mod_side.mode == MODE_STROBE_W) dside_c.pal = PAL_STROBE_W;
					den_c = len_eff;
					if (a0_ok) begin
						dside_c.src = SRC_DIV;
						num_c       = len_eff - a0[IVL_W-1:0];
					end else if (a1_ok) begin
						dside_c.src = SRC_DIV;
						num_c       = len_eff - a1[IVL_W-1:0];
					end
				end
			end
			MODE_GAIN:  dside_c.src = SRC_GAIN;
			default:    dside_c.src = SRC_ZERO;
		endcase
	end

	logic             vld_s2;
	logic [IVL_W-1:0] dnum_s2;
	logic [IVL_W-1:0] dden_s2;
	div_side_t        dside_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= mod_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dnum_s2  <= num_c;
			dden_s2  <= den_c;
			dside_s2 <= dside_c;
		end
	end

	logic               div_vld;
	logic [RATIO_W-1:0] div_quot;
	div_side_t          div_side;

	lclp_div_pipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (vld_s2),
		.in_num    (dnum_s2),
		.in_den    (dden_s2),
		.in_side   (dside_s2),
		.out_valid (div_vld),
		.out_quot  (div_quot),
		.out_side  (div_side)
	);

	// stage 3: curve ROM read alongside the quotient
	logic               vld_s3;
	logic [RATIO_W-1:0] quot_s3;
	div_side_t          side_s3;
	logic [RATIO_W-1:0] curve_s3;

	lclp_curve_rom u_rom (
		.clk  (clk),
		.en   (adv),
		.addr (div_side.gidx),
		.fest (mode_flags_q[0]),
		.data (curve_s3)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			quot_s3 <= div_quot;
			side_s3 <= div_side;
		end
	end

	// stage 4: ratio select and blend products
	logic [RATIO_W-1:0] ratio;
	logic [RATIO_W-1:0] ratio_c;
	logic [RATIO_W-1:0] inv_ratio;
	logic [31:0]        lo_col;
	logic [31:0]        hi_col;

	always_comb begin
		case (side_s3.src)
			SRC_DIV:  ratio = quot_s3;
			SRC_GAIN: ratio = curve_s3;
			SRC_ONE:  ratio = RATIO_ONE;
			SRC_HALF: ratio = RATIO_HALF;
			default:  ratio = '0;
		endcase
		case (side_s3.pal)
			PAL_STROBE_W: begin
				lo_col = 32'h0000_0000;
				hi_col = 32'h0000_00FF;
			end
			PAL_FULL_W: begin
				lo_col = 32'h0000_00FF;
				hi_col = 32'h0000_00FF;
			end
			default: begin
				lo_col = color_low_q;
				hi_col = color_high_q;
			end
		endcase
	end

	assign ratio_c   = (ratio > RATIO_ONE) ? RATIO_ONE : ratio;
	assign inv_ratio = RATIO_ONE - ratio_c;

	logic              vld_s4;
	logic [RATIO_W+7:0] plo_s4 [4];
	logic [RATIO_W+7:0] phi_s4 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3;
		end
	end

	for (genvar c = 0; c < 4; c++) begin : g_lane
		always_ff @(posedge clk) begin
			if (adv) begin
				plo_s4[c] <= (RATIO_W+8)'(lo_col[31-8*c -: 8]) * (RATIO_W+8)'(inv_ratio);
				phi_s4[c] <= (RATIO_W+8)'(hi_col[31-8*c -: 8]) * (RATIO_W+8)'(ratio_c);
			end
		end
	end

	// stage 5: round and drop the fraction
	logic [RATIO_W+8:0] sum_c [4];
	result_t            res_c;
	result_t            result_s5;

	for (genvar c = 0; c < 4; c++) begin : g_sum
		assign sum_c[c] = {1'b0, plo_s4[c]} + {1'b0, phi_s4[c]} + (RATIO_W+9)'(32768);
	end

	assign res_c.red   = sum_c[0][23:16];
	assign res_c.green = sum_c[1][23:16];
	assign res_c.blue  = sum_c[2][23:16];
	assign res_c.white = sum_c[3][23:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_s5 <= res_c;
		end
	end

	assign result_valid = vld_s5;
	assign result       = result_s5;

	a_mod_rem_below_period: assert property (@(posedge clk) disable iff (!arst_n)
		mod_vld |-> (mod_rem < mod_side.d))
		else $error("time remainder not below chase period");

	a_div_num_le_den: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && dside_s2.src == SRC_DIV) |-> (dnum_s2 <= dden_s2 && dden_s2 != '0))
		else $error("divider operands out of range");

	a_quot_le_one: assert property (@(posedge clk) disable iff (!arst_n)
		(div_vld && div_side.src == SRC_DIV) |-> (div_quot <= RATIO_ONE))
		else $error("ratio quotient above one");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s5 && result_stall) |=> (vld_s5 && $stable(result_s5) && $stable(vld_s4)))
		else $error("pipeline moved during a stalled result");

endmodule

### hw/rtl/lclp_curve_rom.sv
// Gain curve ROM, soft and festival tables, registered read.
module lclp_curve_rom
	import lclp_pkg::*;
(
	input  logic                clk,
	input  logic                en,
	input  logic [CURVE_AW-1:0] addr,
	input  logic                fest,
	output logic [RATIO_W-1:0]  data
);

	localparam curve_tab_t SOFT_TAB = build_curve(1'b0);
	localparam curve_tab_t FEST_TAB = build_curve(1'b1);

	always_ff @(posedge clk) begin
		if (en) begin
			data <= fest ? FEST_TAB[addr] : SOFT_TAB[addr];
		end
	end

endmodule

### hw/rtl/lclp_mod_pipe.sv
// Pipelined remainder of the time by the chase period, one dividend bit per stage.
module lclp_mod_pipe
	import lclp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_valid,
	input  logic [TIME_W-1:0] in_num,
	input  mod_side_t         in_side,
	output logic              out_valid,
	output logic [D_W-1:0]    out_rem,
	output mod_side_t         out_side
);

	logic              vld_s  [MOD_STAGES];
	logic [D_W-1:0]    rem_s  [MOD_STAGES];
	logic [TIME_W-1:0] num_s  [MOD_STAGES];
	mod_side_t         side_s [MOD_STAGES];

	for (genvar k = 0; k < MOD_STAGES; k++) begin : g_stage
		logic              vld_in;
		logic [D_W-1:0]    rem_in;
		logic [TIME_W-1:0] num_in;
		mod_side_t         side_in;
		logic [D_W:0]      trial;

		if (k == 0) begin : g_first
			assign vld_in  = in_valid;
			assign rem_in  = '0;
			assign num_in  = in_num;
			assign side_in = in_side;
		end else begin : g_next
			assign vld_in  = vld_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign num_in  = num_s[k-1];
			assign side_in = side_s[k-1];
		end

		// bring down the next dividend bit
		assign trial = {rem_in, num_in[TIME_W-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if (trial >= {1'b0, side_in.d}) begin
					rem_s[k] <= D_W'(trial - {1'b0, side_in.d});
				end else begin
					rem_s[k] <= trial[D_W-1:0];
				end
				num_s[k]  <= {num_in[TIME_W-2:0], 1'b0};
				side_s[k] <= side_in;
			end
		end
	end

	assign out_valid = vld_s[MOD_STAGES-1];
	assign out_rem   = rem_s[MOD_STAGES-1];
	assign out_side  = side_s[MOD_STAGES-1];

endmodule

### hw/rtl/lclp_div_pipe.sv
// Pipelined ratio divider: (num << 16) / den with num <= den, one quotient bit per stage.
module lclp_div_pipe
	import lclp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_valid,
	input  logic [IVL_W-1:0]   in_num,
	input  logic [IVL_W-1:0]   in_den,
	input  div_side_t          in_side,
	output logic               out_valid,
	output logic [RATIO_W-1:0] out_quot,
	output div_side_t          out_side
);

	logic               vld_s  [DIV_STAGES];
	logic [IVL_W-1:0]   rem_s  [DIV_STAGES];
	logic [IVL_W-1:0]   den_s  [DIV_STAGES];
	logic [RATIO_W-1:0] quot_s [DIV_STAGES];
	div_side_t          side_s [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic               vld_in;
		logic [IVL_W-1:0]   den_in;
		logic [RATIO_W-1:0] quot_in;
		div_side_t          side_in;
		logic [IVL_W:0]     trial;
		logic               qbit;

		if (k == 0) begin : g_first
			assign vld_in  = in_valid;
			assign den_in  = in_den;
			assign quot_in = '0;
			assign side_in = in_side;
			assign trial   = {1'b0, in_num};
		end else begin : g_next
			assign vld_in  = vld_s[k-1];
			assign den_in  = den_s[k-1];
			assign quot_in = quot_s[k-1];
			assign side_in = side_s[k-1];
			assign trial   = {rem_s[k-1], 1'b0};
		end

		assign qbit = (trial >= {1'b0, den_in});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k]  <= qbit ? IVL_W'(trial - {1'b0, den_in}) : trial[IVL_W-1:0];
				quot_s[k] <= {quot_in[RATIO_W-2:0], qbit};
				den_s[k]  <= den_in;
				side_s[k] <= side_in;
			end
		end
	end

	assign out_valid = vld_s[DIV_STAGES-1];
	assign out_quot  = quot_s[DIV_STAGES-1];
	assign out_side  = side_s[DIV_STAGES-1];

endmodule
